>>> src/wlf_pkg.sv
// Shared types, constants and tables for the waypoint list follower.
package wlf_pkg;

   localparam int MAX_WAYPOINTS_DEF = 64;
   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int UID_W  = 7;
   localparam int POS_W  = 24;
   localparam int TOL_W  = 16;
   localparam int SPD_W  = 16;
   localparam int YAW_W  = 16;
   localparam int EFF_W  = 16;
   localparam int CSR_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CV_W   = 34;   // cordic x/y datapath width
   localparam int ANG_W  = 26;   // cordic angle accumulator width
   localparam int FINE_PI = 8388608;
   localparam logic [15:0] INV_GAIN = 16'd39797;
   localparam logic [22:0] ROT_MULT = 23'd4117748;

   typedef enum logic [2:0] {
      CMD_LOAD  = 3'd0,
      CMD_CLEAR = 3'd1,
      CMD_EXEC  = 3'd2,
      CMD_SPEED = 3'd3,
      CMD_TICK  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNKNOWN  = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_DEF_TOL = 2'd0,
      CSR_MIN_TOL = 2'd1,
      CSR_ALIGN   = 2'd2,
      CSR_LIMIT   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      cmd_type            command;
      logic [UID_W-1:0]   entry_uid;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [TOL_W-1:0]   tolerance;
      logic               tolerance_given;
      logic [UID_W-1:0]   next_uid;
      logic               start_given;
      logic [SPD_W-1:0]   speed;
      logic signed [YAW_W-1:0] yaw;
   } req_type;

   typedef struct packed {
      logic signed [EFF_W-1:0] linear_effort;
      logic signed [EFF_W-1:0] rotational_effort;
      logic [UID_W-1:0]   active_uid;
      logic               arrived;
      status_type         status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch request word, start table read at its uid
      logic do_item;    // execute non-tick command / tick pre-check
      logic rd_cur;     // read table at current uid
      logic chk_tol;    // tolerance test on read data
      logic rd_tgt;     // read table at (possibly advanced) current uid
      logic cord_init;  // load cordic registers
      logic cord_step;  // one cordic iteration
      logic fin_dist;   // distance multiply, heading error and turn test
      logic fin_err;    // distance rounding and heading error multiply
      logic fin_lin;    // distance times speed
      logic fin_out;    // saturate and form result
      logic rsp_load;   // result to output register
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tick;
      logic has_target;
      logic cord_last;
   } sts_type;

   function automatic logic [ANG_W-1:0] atan_fine(input logic [4:0] i);
      logic [ANG_W-1:0] r;
      case (i)
         5'd0:  r = 26'd2097152;
         5'd1:  r = 26'd1238021;
         5'd2:  r = 26'd654136;
         5'd3:  r = 26'd332050;
         5'd4:  r = 26'd166669;
         5'd5:  r = 26'd83416;
         5'd6:  r = 26'd41718;
         5'd7:  r = 26'd20860;
         5'd8:  r = 26'd10430;
         5'd9:  r = 26'd5215;
         5'd10: r = 26'd2608;
         5'd11: r = 26'd1304;
         5'd12: r = 26'd652;
         5'd13: r = 26'd326;
         5'd14: r = 26'd163;
         5'd15: r = 26'd81;
         5'd16: r = 26'd41;
         5'd17: r = 26'd20;
         5'd18: r = 26'd10;
         5'd19: r = 26'd5;
         5'd20: r = 26'd3;
         5'd21: r = 26'd1;
         5'd22: r = 26'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> src/wlf_stream_if.sv
// Valid/ready stream interface carrying one word of a given type.
interface wlf_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/waypoint_list_follower.sv
// Top level of the waypoint list follower.
// One request word is handled at a time, from acceptance to result. A non-tick command is
// executed and answered directly; a tick whose target is reached onto the end of the list is
// answered after the table reads and tolerance test; a tick with a target also passes the
// iterative CORDIC unit, which does one micro-rotation per cycle, and the effort stages.
// The result word waits in an output register; while it is not taken the next result cannot
// be loaded and a request accepted meanwhile waits for it. No clearing pass is needed after reset.
module waypoint_list_follower #(
   parameter int MAX_WAYPOINTS = wlf_pkg::MAX_WAYPOINTS_DEF,
   parameter int CORDIC_STEPS  = wlf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   wlf_stream_if.sink                    req,
   wlf_stream_if.source                  rsp,
   input  logic                          csr_write,
   input  logic [wlf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wlf_pkg::CSR_W-1:0]     csr_data
);
   import wlf_pkg::*;

   ctl_type ctl;
   sts_type sts;

   wlf_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .ctl
   );

   wlf_datapath #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset,
      .req_word(req.payload),
      .csr_write, .csr_index, .csr_data,
      .ctl, .sts,
      .rsp_word(rsp.payload)
   );
endmodule

>>> src/wlf_ctrl.sv
// Sequencing state machine for one request word.
module wlf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  wlf_pkg::sts_type  sts,
   output wlf_pkg::ctl_type  ctl
);
   import wlf_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_ITEM  = 12'b000000000010,
      S_RDCUR = 12'b000000000100,
      S_CHK   = 12'b000000001000,
      S_RDTGT = 12'b000000010000,
      S_INIT  = 12'b000000100000,
      S_STEP  = 12'b000001000000,
      S_DIST  = 12'b000010000000,
      S_ERR   = 12'b000100000000,
      S_LIN   = 12'b001000000000,
      S_OUT   = 12'b010000000000,
      S_RSP   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   wire out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
            if (req_valid) state_in = S_ITEM;
         end
         S_ITEM: begin
            ctl.do_item = 1'b1;
            state_in = (sts.is_tick && sts.has_target) ? S_RDCUR : S_RSP;
         end
         S_RDCUR: begin
            ctl.rd_cur = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            ctl.chk_tol = 1'b1;
            state_in = S_RDTGT;
         end
         S_RDTGT: begin
            ctl.rd_tgt = 1'b1;
            state_in = sts.has_target ? S_INIT : S_RSP;
         end
         S_INIT: begin
            ctl.cord_init = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            ctl.cord_step = 1'b1;
            if (sts.cord_last) state_in = S_DIST;
         end
         S_DIST: begin
            ctl.fin_dist = 1'b1;
            state_in = S_ERR;
         end
         S_ERR: begin
            ctl.fin_err = 1'b1;
            state_in = S_LIN;
         end
         S_LIN: begin
            ctl.fin_lin = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            ctl.fin_out = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (out_free) begin
               ctl.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

>>> src/wlf_datapath.sv
// Waypoint table, list state, CORDIC vectoring unit and effort arithmetic.
module wlf_datapath #(
   parameter int MAX_WAYPOINTS = wlf_pkg::MAX_WAYPOINTS_DEF,
   parameter int CORDIC_STEPS  = wlf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wlf_pkg::req_type              req_word,
   input  logic                          csr_write,
   input  logic [wlf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wlf_pkg::CSR_W-1:0]     csr_data,
   input  wlf_pkg::ctl_type              ctl,
   output wlf_pkg::sts_type              sts,
   output wlf_pkg::rsp_type              rsp_word
);
   import wlf_pkg::*;

   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int SW = $clog2(CORDIC_STEPS);
   localparam logic [UID_W-1:0] MAX_UID = UID_W'(MAX_WAYPOINTS);
   localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);
   // floor(n / 100) = (n * LIN_RECIP) >> 29 for n below 2^22
   localparam logic [22:0] LIN_RECIP = 23'd5368710;
   localparam int LIN_SAT_N = 3276799;   // largest n with n / 100 below 32768

   // csr
   logic [15:0] def_tol_ff, min_tol_ff;
   logic [14:0] align_ff, limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         def_tol_ff <= 16'd1280;
         min_tol_ff <= 16'd256;
         align_ff   <= 15'd522;
         limit_ff   <= 15'd25600;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_DEF_TOL: def_tol_ff <= csr_data;
            CSR_MIN_TOL: min_tol_ff <= csr_data;
            CSR_ALIGN:   align_ff   <= csr_data[14:0];
            CSR_LIMIT:   limit_ff   <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // request word
   req_type req_ff;
   always_ff @(posedge clock) if (ctl.capture) req_ff <= req_word;

   // table memory: x, y, tol(given,value), next
   localparam int ENT_W = 2*POS_W + 17 + UID_W;
   logic [ENT_W-1:0] mem [MAX_WAYPOINTS];
   logic [ENT_W-1:0] rd_ff;
   logic [MAX_WAYPOINTS-1:0] valid_ff;
   logic [UID_W-1:0] first_ff, cur_ff, rd_addr;
   logic [SPD_W-1:0] speed_ff;

   function automatic logic in_range(input logic [UID_W-1:0] u);
      return (u != '0) && (u <= MAX_UID);
   endfunction
   function automatic logic [AW-1:0] slot(input logic [UID_W-1:0] u);
      logic [UID_W-1:0] k;
      k = u - 1'b1;
      return k[AW-1:0];
   endfunction
   function automatic logic ok(input logic [UID_W-1:0] u, input logic [MAX_WAYPOINTS-1:0] v);
      return in_range(u) && v[slot(u)];
   endfunction

   wire load_en = ctl.do_item && req_ff.command == CMD_LOAD && in_range(req_ff.entry_uid);
   always_ff @(posedge clock) begin
      if (load_en)
         mem[slot(req_ff.entry_uid)] <= {req_ff.pos_x, req_ff.pos_y, req_ff.tolerance_given,
                                         req_ff.tolerance, req_ff.next_uid};
      rd_ff <= mem[slot(rd_addr)];
   end

   logic signed [POS_W-1:0] wx, wy;
   logic               wtg;
   logic [TOL_W-1:0]   wtol;
   logic [UID_W-1:0]   wnext;
   assign {wx, wy, wtg, wtol, wnext} = rd_ff;

   wire signed [POS_W:0] dx = {wx[POS_W-1], wx} - {req_ff.pos_x[POS_W-1], req_ff.pos_x};
   wire signed [POS_W:0] dy = {wy[POS_W-1], wy} - {req_ff.pos_y[POS_W-1], req_ff.pos_y};
   wire [POS_W:0] adx = dx[POS_W] ? -dx : dx;
   wire [POS_W:0] ady = dy[POS_W] ? -dy : dy;

   logic [TOL_W-1:0] tsel, teff;
   always_comb begin
      tsel = wtg ? wtol : def_tol_ff;
      teff = (tsel < min_tol_ff) ? min_tol_ff : tsel;
   end

   status_type status_ff;
   logic       arrived_ff;
   always_comb rd_addr = ctl.capture ? req_word.entry_uid : cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         first_ff <= '0;
         cur_ff   <= '0;
         speed_ff <= '0;
      end else if (ctl.do_item) begin
         case (req_ff.command)
            CMD_LOAD: if (in_range(req_ff.entry_uid)) begin
               valid_ff[slot(req_ff.entry_uid)] <= 1'b1;
               if (first_ff == '0) first_ff <= req_ff.entry_uid;
            end
            CMD_CLEAR: begin
               valid_ff <= '0;
               first_ff <= '0;
               cur_ff   <= '0;
            end
            CMD_EXEC: if (!(req_ff.start_given && !in_range(req_ff.entry_uid))) begin
               if (ok(req_ff.start_given ? req_ff.entry_uid : first_ff, valid_ff)) begin
                  cur_ff   <= req_ff.start_given ? req_ff.entry_uid : first_ff;
                  speed_ff <= req_ff.speed;
               end
            end
            CMD_SPEED: speed_ff <= req_ff.speed;
            CMD_TICK: if (!ok(cur_ff, valid_ff)) cur_ff <= '0;
            default: ;
         endcase
      end else if (ctl.chk_tol) begin
         if ({1'b0, adx} < {10'b0, teff} && {1'b0, ady} < {10'b0, teff})
            cur_ff <= ok(wnext, valid_ff) ? wnext : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.do_item) begin
         arrived_ff <= 1'b0;
         status_ff  <= ST_OK;
         if (req_ff.command == CMD_LOAD && !in_range(req_ff.entry_uid)) status_ff <= ST_RANGE;
         if (req_ff.command == CMD_EXEC) begin
            if (req_ff.start_given && !in_range(req_ff.entry_uid)) status_ff <= ST_RANGE;
            else if (!ok(req_ff.start_given ? req_ff.entry_uid : first_ff, valid_ff))
               status_ff <= ST_UNKNOWN;
         end
      end else if (ctl.chk_tol) begin
         arrived_ff <= ({1'b0, adx} < {10'b0, teff} && {1'b0, ady} < {10'b0, teff});
      end
   end

   // cordic
   logic signed [CV_W-1:0] cx_ff, cy_ff;
   logic signed [ANG_W-1:0] cz_ff;
   logic [SW-1:0] step_ff;
   logic zero_ff;
   wire signed [CV_W-1:0] sx = {{(CV_W-POS_W-7){dx[POS_W]}}, dx, 6'b0};
   wire signed [CV_W-1:0] sy = {{(CV_W-POS_W-7){dy[POS_W]}}, dy, 6'b0};
   wire signed [CV_W-1:0] xs = cx_ff >>> step_ff;
   wire signed [CV_W-1:0] ys = cy_ff >>> step_ff;
   wire signed [ANG_W-1:0] at = ANG_W'(atan_fine(5'(step_ff)));
   localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(FINE_PI / 2);

   always_ff @(posedge clock) begin
      if (ctl.cord_init) begin
         step_ff <= '0;
         zero_ff <= (dx == '0) && (dy == '0);
         if (sx < 0) begin
            if (sy >= 0) begin cx_ff <= sy;  cy_ff <= -sx; cz_ff <= HALF_PI;  end
            else         begin cx_ff <= -sy; cy_ff <= sx;  cz_ff <= -HALF_PI; end
         end else begin
            cx_ff <= sx; cy_ff <= sy; cz_ff <= '0;
         end
      end else if (ctl.cord_step) begin
         step_ff <= step_ff + 1'b1;
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs; cz_ff <= cz_ff + at;
         end else begin
            cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs; cz_ff <= cz_ff - at;
         end
      end
   end

   // finish: distance, heading error, efforts
   logic [CV_W+15:0] dprod_ff;
   logic [25:0] dist_ff;
   logic signed [24:0] err_ff;
   logic [25+SPD_W:0] lprod_ff;
   logic signed [48:0] rprod_ff;
   logic turn_ff;
   logic [CV_W-2:0] xpos;
   assign xpos = cx_ff[CV_W-1] ? '0 : cx_ff[CV_W-2:0];

   logic [23:0] u;
   logic signed [24:0] e;
   logic [24:0] emag;
   always_comb begin
      u = 24'(cz_ff - ANG_W'(signed'({req_ff.yaw, 8'b0})));
      e = (u > 24'(FINE_PI)) ? 25'(signed'({1'b0, u})) - 25'(2*FINE_PI)
                             : signed'({1'b0, u});
      if (zero_ff) begin
         u = 24'(-signed'({req_ff.yaw, 8'b0}));
         e = (u > 24'(FINE_PI)) ? 25'(signed'({1'b0, u})) - 25'(2*FINE_PI)
                                : signed'({1'b0, u});
      end
      emag = e[24] ? 25'(-e) : 25'(e);
   end

   always_ff @(posedge clock) begin
      if (ctl.fin_dist) begin
         dprod_ff <= (CV_W+16)'(xpos) * INV_GAIN;
         err_ff   <= e;
         turn_ff  <= emag > {2'b0, align_ff, 8'b0};
      end
      if (ctl.fin_err) begin
         dist_ff  <= zero_ff ? '0 : 26'((dprod_ff + (CV_W+16)'(1 << 21)) >> 22);
         rprod_ff <= 49'(-err_ff) * signed'({1'b0, ROT_MULT}) + 49'(1 << 30);
      end
      if (ctl.fin_lin)
         lprod_ff <= dist_ff * speed_ff;
   end

   // linear effort = floor(floor(prod / 256) / 100), saturated
   logic signed [EFF_W-1:0] lin_ff, rot_ff;
   logic        lbig;
   logic [21:0] ln;
   logic [44:0] lrecip;
   logic [14:0] lq;
   logic signed [17:0] rq;
   logic signed [17:0] lim;
   assign lbig   = lprod_ff[25+SPD_W:8] > (18+SPD_W)'(LIN_SAT_N);
   assign ln     = lprod_ff[29:8];
   assign lrecip = 45'(ln) * LIN_RECIP;
   assign lq     = lrecip[43:29];
   assign rq = 18'(rprod_ff >>> 31);
   assign lim = signed'({3'b0, limit_ff});

   always_ff @(posedge clock) begin
      if (ctl.do_item) begin
         lin_ff <= '0; rot_ff <= '0;
      end else if (ctl.fin_out) begin
         if (turn_ff) begin
            rot_ff <= (rq > lim) ? EFF_W'(lim) : (rq < -lim) ? EFF_W'(-lim) : EFF_W'(rq);
         end else begin
            lin_ff <= (lbig || lq > limit_ff) ? EFF_W'(limit_ff) : EFF_W'(lq);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_word.linear_effort     <= lin_ff;
         rsp_word.rotational_effort <= rot_ff;
         rsp_word.active_uid        <= cur_ff;
         rsp_word.arrived           <= arrived_ff;
         rsp_word.status            <= status_ff;
      end
   end

   assign sts.is_tick    = req_ff.command == CMD_TICK;
   assign sts.has_target = ctl.do_item ? ok(cur_ff, valid_ff) : (cur_ff != '0);
   assign sts.cord_last  = step_ff == LAST_STEP;
endmodule
